>>> design/sxpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the horizontal Sobel prefilter.
// Used by the channel interfaces and every module of the block; depends on nothing.
package sxpc_pkg;

	// Default geometry limits for the line stores and counters.
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Field widths fixed by the stream format.
	localparam int PIX_W     = 8;
	localparam int VAL_W     = 8;
	localparam int ROW_OUT_W = 12;
	localparam int COL_OUT_W = 11;

	// Signed Sobel sum: the range -1020..1020 fits 11 bits.
	localparam int SUM_W = 11;

	// Configuration register widths and the write port.
	localparam int CAP_W      = 7;
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd100;
	localparam logic [FW_W-1:0]  FW_RESET  = 12'd1280;
	localparam logic [FH_W-1:0]  FH_RESET  = 13'd720;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLAMP_CAP    = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} cfg_reg_t;

	// Depth of the job queue between the front and the back end.
	localparam int Q_DEPTH = 4;

	// Result slots of one job, in emission order.
	localparam int E_PREV_ROW = 0;  // pixel (r-1, c-1), carries the Sobel value
	localparam int E_CUR_ROW  = 1;  // pixel (r, c-1) on the last row
	localparam int E_PREV_END = 2;  // pixel (r-1, w-1) at a row end
	localparam int E_CUR_END  = 3;  // pixel (r, w-1) at a row end of the last row
	localparam int N_SLOTS    = 4;

	// One classified input beat: everything the back end needs to emit its results.
	typedef struct packed {
		logic [VAL_W-1:0]     value;
		logic [ROW_OUT_W-1:0] row_prev;
		logic [ROW_OUT_W-1:0] row_cur;
		logic [COL_OUT_W-1:0] col_prev;
		logic [COL_OUT_W-1:0] col_end;
		logic [N_SLOTS-1:0]   emit;
		logic                 frame_end;
	} job_t;

	// Queue status seen by the front and back ends.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> design/sxpc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pixel input and the result output.
// Depends on sxpc_pkg for the field widths.
interface sxpc_pix_if;
	import sxpc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] gray_pixel;

	modport source (output valid, output gray_pixel, input ready);
	modport sink   (input valid, input gray_pixel, output ready);
endinterface

interface sxpc_res_if;
	import sxpc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VAL_W-1:0]     filtered_value;
	logic [ROW_OUT_W-1:0] out_row;
	logic [COL_OUT_W-1:0] out_col;
	logic                 last_of_run;
	logic                 frame_done;

	modport source (output valid, output filtered_value, output out_row, output out_col,
		output last_of_run, output frame_done, input ready);
	modport sink   (input valid, input filtered_value, input out_row, input out_col,
		input last_of_run, input frame_done, output ready);
endinterface

>>> design/sxpc_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, raster counters, line stores, 3x3 window,
// Sobel sum and clamp; pushes a classified job for each beat that causes a result. Depends on sxpc_pkg, sxpc_if.
module sxpc_front #(
	parameter int MAX_WIDTH  = sxpc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sxpc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sxpc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [sxpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	sxpc_pix_if.sink                            pix,
	input  sxpc_pkg::q_status_t                 q_stat,
	output logic                                q_push,
	output sxpc_pkg::job_t                      q_job
);
	import sxpc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// Configuration registers.
	logic [CAP_W-1:0] cap_q;
	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;

	// Raster position of the next pixel.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Effective geometry, as last index.
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;

	// Classification of the incoming beat.
	logic               last_row;
	logic               row_end;
	logic               interior;
	logic [N_SLOTS-1:0] emit;

	// Pipeline control.
	logic acc;
	logic adv;

	// Stage 1: pixel and line store read data.
	logic               valid_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [PIX_W-1:0]   top_s1;
	logic [PIX_W-1:0]   mid_s1;
	logic [CW-1:0]      col_s1;
	logic [RW-1:0]      row_s1;
	logic               interior_s1;
	logic [N_SLOTS-1:0] emit_s1;
	logic               fend_s1;

	// Stage 2: Sobel sum.
	logic                    valid_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic [CW-1:0]           col_s2;
	logic [RW-1:0]           row_s2;
	logic                    interior_s2;
	logic [N_SLOTS-1:0]      emit_s2;
	logic                    fend_s2;

	// Window: two previous columns of the top, middle and bottom rows.
	logic [PIX_W-1:0] win_q [6];

	// Line stores, rows r-2 and r-1.
	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

	logic signed [SUM_W-1:0] e_top;
	logic signed [SUM_W-1:0] e_mid;
	logic signed [SUM_W-1:0] e_bot;
	logic signed [SUM_W-1:0] e_w0;
	logic signed [SUM_W-1:0] e_w2;
	logic signed [SUM_W-1:0] e_w4;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [SUM_W-1:0] cap_s;
	logic [VAL_W-1:0]        clamped;

	// Width and height are clamped to 1..MAX.
	always_comb begin
		if (frame_width_q == '0) begin
			wm1 = '0;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(frame_width_q - 1'b1);
		end
		if (frame_height_q == '0) begin
			hm1 = '0;
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			hm1 = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = RW'(frame_height_q - 1'b1);
		end
	end

	// Classify the beat at the current raster position.
	always_comb begin
		last_row = (row_q >= hm1);
		row_end  = (col_q >= wm1);
		interior = (row_q >= RW'(2)) && (row_q <= hm1) && (col_q >= CW'(2)) && (col_q <= wm1)
			&& (hm1 >= RW'(2)) && (wm1 >= CW'(2));
		emit             = '0;
		emit[E_PREV_ROW] = (col_q != '0) && (row_q != '0);
		emit[E_CUR_ROW]  = (col_q != '0) && last_row;
		emit[E_PREV_END] = row_end && (row_q != '0);
		emit[E_CUR_END]  = row_end && last_row;
	end

	// The whole front stalls only when stage 2 holds a job the queue cannot take.
	assign adv       = !(valid_s2 && (emit_s2 != '0) && q_stat.full);
	assign pix.ready = adv;
	assign acc       = pix.valid && adv;

	// Configuration registers and raster counters; a geometry write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q          <= CAP_RESET;
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CLAMP_CAP: begin
					cap_q <= cfg_data[CAP_W-1:0];
				end
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[FW_W-1:0];
					col_q         <= '0;
					row_q         <= '0;
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[FH_W-1:0];
					col_q          <= '0;
					row_q          <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Line stores: read on accept, written back when the beat leaves stage 1.
	always_ff @(posedge clk) begin
		if (acc) begin
			top_s1 <= older_mem[col_q];
			mid_s1 <= newer_mem[col_q];
		end
		if (valid_s1 && adv) begin
			older_mem[col_s1] <= mid_s1;
			newer_mem[col_s1] <= pix_s1;
		end
	end

	// Pipeline valid bits and the window shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				win_q[0] <= win_q[1];
				win_q[1] <= top_s1;
				win_q[2] <= win_q[3];
				win_q[3] <= mid_s1;
				win_q[4] <= win_q[5];
				win_q[5] <= pix_s1;
			end
		end
	end

	// Horizontal Sobel sum with the middle row weighted twice.
	always_comb begin
		e_top  = SUM_W'(top_s1);
		e_mid  = SUM_W'(mid_s1);
		e_bot  = SUM_W'(pix_s1);
		e_w0   = SUM_W'(win_q[0]);
		e_w2   = SUM_W'(win_q[2]);
		e_w4   = SUM_W'(win_q[4]);
		sum_s1 = (e_top - e_w0) + ((e_mid - e_w2) <<< 1) + (e_bot - e_w4);
	end

	// Payload of both stages.
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1      <= pix.gray_pixel;
			col_s1      <= col_q;
			row_s1      <= row_q;
			interior_s1 <= interior;
			emit_s1     <= emit;
			fend_s1     <= last_row && row_end;
		end
		if (adv) begin
			sum_s2      <= sum_s1;
			col_s2      <= col_s1;
			row_s2      <= row_s1;
			interior_s2 <= interior_s1;
			emit_s2     <= emit_s1;
			fend_s2     <= fend_s1;
		end
	end

	// Shift by the cap and clamp to 0..2*cap.
	always_comb begin
		cap_s = SUM_W'(cap_q);
		priority if (sum_s2 < -cap_s) begin
			clamped = '0;
		end else if (sum_s2 > cap_s) begin
			clamped = VAL_W'(cap_s <<< 1);
		end else begin
			clamped = VAL_W'(sum_s2 + cap_s);
		end
	end

	// Beats that cause no result are dropped here.
	assign q_push = valid_s2 && (emit_s2 != '0) && !q_stat.full;

	always_comb begin
		q_job.value     = interior_s2 ? clamped : '0;
		q_job.row_prev  = ROW_OUT_W'(row_s2 - 1'b1);
		q_job.row_cur   = ROW_OUT_W'(row_s2);
		q_job.col_prev  = COL_OUT_W'(col_s2 - 1'b1);
		q_job.col_end   = COL_OUT_W'(wm1);
		q_job.emit      = emit_s2;
		q_job.frame_end = fend_s2;
	end

endmodule

>>> design/sxpc_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front and the back end.
// Depends on sxpc_pkg for the job type and the depth.
module sxpc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sxpc_pkg::job_t      push_job,
	input  logic                pop,
	output sxpc_pkg::job_t      pop_job,
	output sxpc_pkg::q_status_t stat
);
	import sxpc_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	job_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_job    = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> design/sxpc_back.sv
`timescale 1ns / 1ps
// Back end: takes one job at a time from the queue and emits its results, one beat a cycle while res.ready is high.
// Depends on sxpc_pkg and sxpc_if.
module sxpc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sxpc_pkg::job_t      job_in,
	input  sxpc_pkg::q_status_t q_stat,
	output logic                pop,
	sxpc_res_if.source          res
);
	import sxpc_pkg::*;

	job_t               job_q;
	logic [N_SLOTS-1:0] mask_q;
	logic [N_SLOTS-1:0] sel;
	logic [N_SLOTS-1:0] rest;
	logic               fire;

	// The lowest pending slot goes out first.
	assign sel  = mask_q & (~mask_q + 1'b1);
	assign rest = mask_q & ~sel;
	assign fire = res.valid && res.ready;

	// Load the next job as soon as the current one has given its last beat.
	assign pop = !q_stat.empty && ((mask_q == '0) || (fire && (rest == '0)));

	always_comb begin
		res.valid          = (mask_q != '0);
		res.filtered_value = sel[E_PREV_ROW] ? job_q.value : '0;
		res.out_row        = (sel[E_PREV_ROW] || sel[E_PREV_END]) ? job_q.row_prev
			: job_q.row_cur;
		res.out_col        = (sel[E_PREV_ROW] || sel[E_CUR_ROW]) ? job_q.col_prev
			: job_q.col_end;
		res.last_of_run    = (rest == '0);
		res.frame_done     = (rest == '0) && job_q.frame_end;
	end

	// Pending slots of the current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= job_in.emit;
		end else if (fire) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_in;
		end
	end

endmodule

>>> design/sobel_x_prefilter_clamp.sv
`timescale 1ns / 1ps
// Top level of the streaming horizontal Sobel prefilter with clamp.
// Depends on sxpc_pkg, sxpc_if, sxpc_front, sxpc_queue and sxpc_back.

// Grayscale pixels enter in raster order at up to one beat per clock, and each result for pixel
// (r-1, c-1) is produced when pixel (r, c) arrives: a value of 0..2*clamp_cap, zero on the border,
// tagged with row, column, last_of_run and frame_done. The result side also runs at one beat per
// clock while res.ready is high, so the sustained input rate is one pixel per cycle away from
// row ends; a row-end pixel gives up to four results and pixels of the last row two each, which
// the back end emits one per cycle, so a four-entry job queue absorbs the bursts and the input
// stalls once it is full. A pixel's first result is offered after the line store read, the Sobel
// sum with clamp, the queue write and the back-end load, in that order. Two line stores of
// MAX_WIDTH bytes hold the previous rows, each read at one address and written at another in the
// same cycle; they have no reset and no clearing pass. Writing frame_width or frame_height
// restarts the frame, and a new clamp_cap applies to results not yet queued; the user must write
// configuration only while the block is idle, and the block itself does not enforce it.
module sobel_x_prefilter_clamp #(
	parameter int MAX_WIDTH  = sxpc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sxpc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sxpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sxpc_pkg::CFG_DATA_W-1:0] cfg_data,
	sxpc_pix_if.sink                        pix,
	sxpc_res_if.source                      res
);
	import sxpc_pkg::*;

	logic      q_push;
	logic      q_pop;
	job_t      push_job;
	job_t      pop_job;
	q_status_t q_stat;

	// Front end: classify each pixel beat and form its job.
	sxpc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.pix     (pix),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_job   (push_job)
	);

	// Job queue decoupling the two halves.
	sxpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.pop     (q_pop),
		.pop_job (pop_job),
		.stat    (q_stat)
	);

	// Back end: emit the results of each job.
	sxpc_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.job_in(pop_job),
		.q_stat(q_stat),
		.pop   (q_pop),
		.res   (res)
	);

	// The final result of a frame also closes the run of its pixel.
	a_frame_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_done |-> res.last_of_run)
		else $error("frame_done without last_of_run");

	// The input only stalls on a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> q_stat.full)
		else $error("input stalled while the queue has room");

	// Only jobs that cause results enter the queue.
	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (push_job.emit != '0))
		else $error("empty job pushed");

	// A waiting job follows the last beat of the current one without a gap.
	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && res.last_of_run && !q_stat.empty |=> res.valid)
		else $error("gap between queued jobs");

endmodule
